>>> hw/rtl/pctr_pkg.sv
// ----------------------------------------------------------------------------
// pctr_pkg: shared types and codes for the peer candidate table
// Request and result layouts, command and status codes, the token that walks
// the cell chain and the per-cycle control broadcast to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package pctr_pkg;

  localparam logic [1:0] CMD_UPSERT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_ENTRY    = 3'd4;
  localparam logic [2:0] ST_ABSENT   = 3'd5;

  typedef struct packed {
    logic [1:0]        command;
    logic [47:0]       station_addr;
    logic [7:0]        peer_channel;
    logic signed [7:0] peer_rssi;
    logic [31:0]       now_ms;
    logic [7:0]        want_rank;
  } in_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [47:0]       out_addr;
    logic [7:0]        out_channel;
    logic signed [7:0] out_rssi;
    logic [31:0]       out_seen_ms;
    logic [4:0]        out_count;
  } out_res_t;

  // Request token travelling one cell per cycle. For a read, the entry
  // fields are overwritten by the cell that holds the wanted rank.
  typedef struct packed {
    logic              vld;
    logic [1:0]        cmd;
    logic [47:0]       addr;
    logic [7:0]        chan;
    logic signed [7:0] rssi;
    logic [31:0]       seen;
    logic [7:0]        want;
    logic              done;
    logic [2:0]        status;
  } tok_t;

  // Strength value rotating around the ring during rank computation.
  typedef struct packed {
    logic              vld;
    logic signed [7:0] rssi;
  } ring_t;

  typedef struct packed {
    logic load_ring;
    logic shift_ring;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RANK,
    S_LAUNCH,
    S_WALK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/pctr_cell.sv
// ----------------------------------------------------------------------------
// pctr_cell: one table slot of the peer candidate chain
// Holds one entry, works on the request token passing through, and counts
// its own strength rank from the values rotating around the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module pctr_cell #(
  parameter int TABLE_ENTRIES = 16,
  parameter int CELL_INDEX    = 0,
  localparam int CW = $clog2(TABLE_ENTRIES + 1),
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pctr_pkg::cell_ctl_t  ctl,
  input  wire [CW-1:0]         fill,
  input  pctr_pkg::tok_t       tok_in,
  output pctr_pkg::tok_t       tok_out,
  input  pctr_pkg::ring_t      ring_in,
  input  wire [IW-1:0]         ring_in_idx,
  output pctr_pkg::ring_t      ring_out,
  output logic [IW-1:0]        ring_out_idx
);

  logic [47:0]        addr_r;
  logic [7:0]         chan_r;
  logic signed [7:0]  rssi_r;
  logic [31:0]        seen_r;
  logic [IW-1:0]      rank_r;
  pctr_pkg::tok_t     tok_r, tok_nxt;
  pctr_pkg::ring_t    ring_r;
  logic [IW-1:0]      ring_idx_r;
  logic               mine_valid, at_tail, wr_en, beats_me;

  assign mine_valid = (CW'(CELL_INDEX) < fill);
  assign at_tail    = (CW'(CELL_INDEX) == fill);

  always_comb begin
    tok_nxt = tok_in;
    wr_en   = 1'b0;
    if (tok_in.vld && !tok_in.done) begin
      if (tok_in.cmd == pctr_pkg::CMD_UPSERT) begin
        if (mine_valid && addr_r == tok_in.addr) begin
          wr_en          = 1'b1;
          tok_nxt.done   = 1'b1;
          tok_nxt.status = pctr_pkg::ST_UPDATED;
        end else if (at_tail) begin
          wr_en          = 1'b1;
          tok_nxt.done   = 1'b1;
          tok_nxt.status = pctr_pkg::ST_APPENDED;
        end
      end else if (tok_in.cmd == pctr_pkg::CMD_READ) begin
        if (mine_valid && 8'(rank_r) == tok_in.want) begin
          tok_nxt.addr   = addr_r;
          tok_nxt.chan   = chan_r;
          tok_nxt.rssi   = rssi_r;
          tok_nxt.seen   = seen_r;
          tok_nxt.done   = 1'b1;
          tok_nxt.status = pctr_pkg::ST_ENTRY;
        end
      end
    end
  end

  // A stronger entry, or an equal one inserted earlier, ranks ahead of this one.
  assign beats_me = ring_in.vld &&
                    (ring_in.rssi > rssi_r ||
                     (ring_in.rssi == rssi_r && ring_in_idx < IW'(CELL_INDEX)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld  <= 1'b0;
      ring_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
      if (ctl.load_ring) begin
        ring_r.vld <= mine_valid;
      end else if (ctl.shift_ring) begin
        ring_r.vld <= ring_in.vld;
      end
    end
    tok_r.cmd    <= tok_nxt.cmd;
    tok_r.addr   <= tok_nxt.addr;
    tok_r.chan   <= tok_nxt.chan;
    tok_r.rssi   <= tok_nxt.rssi;
    tok_r.seen   <= tok_nxt.seen;
    tok_r.want   <= tok_nxt.want;
    tok_r.done   <= tok_nxt.done;
    tok_r.status <= tok_nxt.status;
    if (wr_en) begin
      addr_r <= tok_in.addr;
      chan_r <= tok_in.chan;
      rssi_r <= tok_in.rssi;
      seen_r <= tok_in.seen;
    end
    if (ctl.load_ring) begin
      ring_r.rssi <= rssi_r;
      ring_idx_r  <= IW'(CELL_INDEX);
      rank_r      <= '0;
    end else if (ctl.shift_ring) begin
      ring_r.rssi <= ring_in.rssi;
      ring_idx_r  <= ring_in_idx;
      if (beats_me) begin
        rank_r <= rank_r + IW'(1);
      end
    end
  end

  assign tok_out      = tok_r;
  assign ring_out     = ring_r;
  assign ring_out_idx = ring_idx_r;

endmodule

`default_nettype wire

>>> hw/rtl/peer_candidate_table_rank_core.sv
// ----------------------------------------------------------------------------
// peer_candidate_table_rank_core: ranked table of discovered radio peers
// Keeps up to TABLE_ENTRIES peers keyed by address in a chain of cells,
// answers upserts, clears and reads by strength rank, one result per request.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Direction | Moves
//   --------+--------------------------------+-----------+----------------------
//   input   | in_valid, in_stall, in_data    | into core | one request
//   result  | out_valid, out_stall, out_data | out of    | one result per request
//
// Steps: an upsert goes from acceptance to launch, then the token walks one cell
// per cycle down the chain and the result is taken from the tail. A read that
// hits a valid rank adds a load step and one pass of the strength ring around
// all cells before the launch and token walk. Clears, unused commands and reads
// beyond the fill count go straight to the done state. The core goes idle in
// the cycle after the result is loaded, and only then takes the next request.
// Reset clears the fill count, state and valid flags; table contents are not
// cleared and are never read before being written.
// A stalled result holds in the output register; a new request is taken while
// it waits, and its own result waits in the done state until the register frees.
`default_nettype none

module peer_candidate_table_rank_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  pctr_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output pctr_pkg::out_res_t out_data
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  pctr_pkg::state_t    state_r, state_nxt;
  pctr_pkg::in_req_t   req_r;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [IW-1:0]       step_r, step_nxt;
  logic [2:0]          res_status_r, res_status_nxt;
  logic [47:0]         res_addr_r, res_addr_nxt;
  logic [7:0]          res_chan_r, res_chan_nxt;
  logic signed [7:0]   res_rssi_r, res_rssi_nxt;
  logic [31:0]         res_seen_r, res_seen_nxt;
  logic                out_valid_r;
  pctr_pkg::out_res_t  out_data_r;

  logic                accept, load_out, launch, read_hit;
  pctr_pkg::cell_ctl_t ctl;
  pctr_pkg::tok_t      tok_c [0:TABLE_ENTRIES];
  pctr_pkg::ring_t     ring_c [0:TABLE_ENTRIES-1];
  logic [IW-1:0]       ring_idx_c [0:TABLE_ENTRIES-1];
  pctr_pkg::tok_t      tail;

  assign accept   = in_valid && !in_stall;
  assign read_hit = (in_data.want_rank < 8'(fill_r));
  assign tail     = tok_c[TABLE_ENTRIES];

  // The chain. Each cell passes the token to the next one and hands its ring
  // value to the next one; the last cell closes the ring back to cell zero.
  generate
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      localparam int PREV = (i + TABLE_ENTRIES - 1) % TABLE_ENTRIES;
      pctr_cell #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CELL_INDEX    (i)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .fill         (fill_r),
        .tok_in       (tok_c[i]),
        .tok_out      (tok_c[i+1]),
        .ring_in      (ring_c[PREV]),
        .ring_in_idx  (ring_idx_c[PREV]),
        .ring_out     (ring_c[i]),
        .ring_out_idx (ring_idx_c[i])
      );
    end
  endgenerate

  // Token entering the chain: only valid during the launch cycle.
  always_comb begin
    tok_c[0]      = '0;
    tok_c[0].vld  = launch;
    tok_c[0].cmd  = req_r.command;
    tok_c[0].addr = req_r.station_addr;
    tok_c[0].chan = req_r.peer_channel;
    tok_c[0].rssi = req_r.peer_rssi;
    tok_c[0].seen = req_r.now_ms;
    tok_c[0].want = req_r.want_rank;
    tok_c[0].done = 1'b0;
    if (req_r.command == pctr_pkg::CMD_UPSERT) begin
      tok_c[0].status = pctr_pkg::ST_DROPPED;
    end else begin
      tok_c[0].status = pctr_pkg::ST_ABSENT;
    end
  end

  // Next-state logic, including the result and fill count bookkeeping.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_chan_nxt   = res_chan_r;
    res_rssi_nxt   = res_rssi_r;
    res_seen_nxt   = res_seen_r;
    case (state_r)
      pctr_pkg::S_IDLE: begin
        if (accept) begin
          res_addr_nxt = '0;
          res_chan_nxt = '0;
          res_rssi_nxt = '0;
          res_seen_nxt = '0;
          case (in_data.command)
            pctr_pkg::CMD_UPSERT: begin
              state_nxt = pctr_pkg::S_LAUNCH;
            end
            pctr_pkg::CMD_CLEAR: begin
              fill_nxt       = '0;
              res_status_nxt = pctr_pkg::ST_CLEARED;
              state_nxt      = pctr_pkg::S_DONE;
            end
            pctr_pkg::CMD_READ: begin
              if (read_hit) begin
                state_nxt = pctr_pkg::S_LOAD;
              end else begin
                res_status_nxt = pctr_pkg::ST_ABSENT;
                state_nxt      = pctr_pkg::S_DONE;
              end
            end
            default: begin
              res_status_nxt = pctr_pkg::ST_ABSENT;
              state_nxt      = pctr_pkg::S_DONE;
            end
          endcase
        end
      end
      pctr_pkg::S_LOAD: begin
        step_nxt  = '0;
        state_nxt = pctr_pkg::S_RANK;
      end
      pctr_pkg::S_RANK: begin
        step_nxt = step_r + IW'(1);
        if (step_r == IW'(TABLE_ENTRIES - 1)) begin
          state_nxt = pctr_pkg::S_LAUNCH;
        end
      end
      pctr_pkg::S_LAUNCH: begin
        state_nxt = pctr_pkg::S_WALK;
      end
      pctr_pkg::S_WALK: begin
        if (tail.vld) begin
          res_status_nxt = tail.status;
          if (tail.status == pctr_pkg::ST_ENTRY) begin
            res_addr_nxt = tail.addr;
            res_chan_nxt = tail.chan;
            res_rssi_nxt = tail.rssi;
            res_seen_nxt = tail.seen;
          end
          if (tail.status == pctr_pkg::ST_APPENDED) begin
            fill_nxt = fill_r + CW'(1);
          end
          state_nxt = pctr_pkg::S_DONE;
        end
      end
      pctr_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = pctr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pctr_pkg::S_IDLE;
      end
    endcase
  end

  // Output decode per state.
  always_comb begin
    in_stall       = 1'b1;
    ctl.load_ring  = 1'b0;
    ctl.shift_ring = 1'b0;
    launch         = 1'b0;
    load_out       = 1'b0;
    case (state_r)
      pctr_pkg::S_IDLE:   in_stall       = 1'b0;
      pctr_pkg::S_LOAD:   ctl.load_ring  = 1'b1;
      pctr_pkg::S_RANK:   ctl.shift_ring = 1'b1;
      pctr_pkg::S_LAUNCH: launch         = 1'b1;
      pctr_pkg::S_DONE:   load_out       = !out_valid_r || !out_stall;
      default:            in_stall       = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pctr_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_chan_r   <= res_chan_nxt;
    res_rssi_r   <= res_rssi_nxt;
    res_seen_r   <= res_seen_nxt;
    if (accept) begin
      req_r <= in_data;
    end
    if (load_out) begin
      out_data_r.status      <= res_status_r;
      out_data_r.out_addr    <= res_addr_r;
      out_data_r.out_channel <= res_chan_r;
      out_data_r.out_rssi    <= res_rssi_r;
      out_data_r.out_seen_ms <= res_seen_r;
      out_data_r.out_count   <= 5'(fill_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  // A token leaves the chain only while the walk is in progress.
  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == pctr_pkg::S_WALK)
    else $error("token left the chain outside the walk");

  // Only upserts and reads walk the chain.
  a_walk_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pctr_pkg::S_WALK |->
      (req_r.command == pctr_pkg::CMD_UPSERT || req_r.command == pctr_pkg::CMD_READ))
    else $error("chain walk for a command that needs none");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != pctr_pkg::S_IDLE)
    else $error("accepted request did not start");

endmodule

`default_nettype wire
